// File: design/lph_pkg.sv
// lph_pkg: shared widths, codes and the slot entry type of the hash table
// no dependencies; used by every module of the design
package lph_pkg;

    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_FIND   = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic             occ;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_entry;

endpackage

// File: design/lph_store.sv
// lph_store: slot memory holding occupied flag, key and value per slot
// one write port, one read port with registered read data; uses lph_pkg
module lph_store #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  lph_pkg::t_entry   i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output lph_pkg::t_entry   o_rd_data
);

    lph_pkg::t_entry r_mem [DEPTH];
    lph_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: design/lph_hash.sv
// lph_hash: home slot unit, (2*key - 1) reduced modulo the slot count
// power-of-two counts need only an adder and a register, others a shared reciprocal multiply
// followed by repeated compare-subtract steps; uses lph_pkg
module lph_hash #(
    parameter int TABLE_SLOTS = 1024,
    parameter int SLOT_W      = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [lph_pkg::KEY_W-1:0] i_key,
    output logic                      o_done,
    output logic [SLOT_W-1:0]         o_home
);

    localparam bit IS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;

    generate
        if (IS_POW2) begin : g_pow2
            logic [SLOT_W:0]   p2_sum;
            logic              r_done;
            logic [SLOT_W-1:0] r_home;

            assign p2_sum = {i_key[SLOT_W-1:0], 1'b0} + (SLOT_W+1)'(TABLE_SLOTS - 1);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_home <= p2_sum[SLOT_W-1:0];
                end
            end

            assign o_done = r_done;
            assign o_home = r_home;
        end else begin : g_recip
            localparam int ACC_W = SLOT_W + 3;
            localparam logic [31:0]      SLOTS_32 = 32'(TABLE_SLOTS);
            localparam logic [31:0]      RECIP    = 32'((64'd1 << 32) / 64'(TABLE_SLOTS));
            localparam logic [ACC_W-1:0] SLOTS_A  = ACC_W'(TABLE_SLOTS);
            localparam logic [ACC_W-1:0] SLOTS_M1 = ACC_W'(TABLE_SLOTS - 1);

            typedef enum logic [4:0] {
                H_IDLE = 5'b00001,
                H_QUOT = 5'b00010,
                H_PROD = 5'b00100,
                H_REM  = 5'b01000,
                H_FIX  = 5'b10000
            } t_hphase;

            t_hphase                   r_phase, n_phase;
            logic [lph_pkg::KEY_W-1:0] r_key, n_key;
            logic [63:0]               r_prod, n_prod;
            logic [ACC_W-1:0]          r_acc, n_acc;
            logic [31:0]               mul_a;
            logic [31:0]               mul_b;
            logic [63:0]               mul_p;
            logic [31:0]               rem_est;
            logic [ACC_W-1:0]          acc_sub;
            logic                      acc_ge;
            logic                      done;

            // shared multiplier, key by reciprocal then quotient by slot count
            assign mul_a   = (r_phase == H_QUOT) ? r_key : r_prod[63:32];
            assign mul_b   = (r_phase == H_QUOT) ? RECIP : SLOTS_32;
            assign mul_p   = 64'(mul_a) * 64'(mul_b);
            // quotient estimate at most one low, remainder below twice the slot count
            assign rem_est = r_key - r_prod[31:0];
            assign acc_ge  = r_acc >= SLOTS_A;
            assign acc_sub = r_acc - SLOTS_A;

            always_comb begin
                n_phase = r_phase;
                n_key   = r_key;
                n_prod  = r_prod;
                n_acc   = r_acc;
                done    = 1'b0;
                case (r_phase)
                    H_IDLE: begin
                        if (i_start) begin
                            n_key   = i_key;
                            n_phase = H_QUOT;
                        end
                    end
                    H_QUOT: begin
                        n_prod  = mul_p;
                        n_phase = H_PROD;
                    end
                    H_PROD: begin
                        n_prod  = mul_p;
                        n_phase = H_REM;
                    end
                    H_REM: begin
                        n_acc   = {1'b0, rem_est[SLOT_W:0], 1'b0} + SLOTS_M1;
                        n_phase = H_FIX;
                    end
                    H_FIX: begin
                        if (acc_ge) begin
                            n_acc = acc_sub;
                        end else begin
                            done    = 1'b1;
                            n_phase = H_IDLE;
                        end
                    end
                    default: begin
                        n_phase = H_IDLE;
                    end
                endcase
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_phase <= H_IDLE;
                end else begin
                    r_phase <= n_phase;
                end
            end

            always_ff @(posedge i_clk) begin
                r_key  <= n_key;
                r_prod <= n_prod;
                r_acc  <= n_acc;
            end

            assign o_done = done;
            assign o_home = r_acc[SLOT_W-1:0];
        end
    endgenerate

endmodule

// File: design/linear_probe_hash_table.sv
// linear_probe_hash_table: open-addressing hash table with linear probing, top level
// an accepted item is hashed to its home slot, directly for a power-of-two slot count and
// by reciprocal reduction for other counts; the walk then reads one slot per cycle until
// a free slot, a key match on a find or every slot is read; a new item is taken only after
// the result is loaded; reset: a clearing pass empties every slot before the first item
// depends on lph_pkg, lph_hash and lph_store
module linear_probe_hash_table #(
    parameter int TABLE_SLOTS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // key [31:0], value [63:32]
    input  logic [0:0]  s_axis_tuser,   // action [0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // read_value [31:0]
    output logic [1:0]  m_axis_tuser    // status [1:0]
);

    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_HASH  = 4'b0100,
        S_PROBE = 4'b1000
    } t_state;

    t_state                           r_state, n_state;
    logic [SLOT_W-1:0]                r_clr_addr, n_clr_addr;
    logic [SLOT_W-1:0]                r_slot, n_slot;
    logic [SLOT_W-1:0]                r_probes, n_probes;
    logic                             r_action;
    logic [lph_pkg::KEY_W-1:0]        r_key;
    logic [lph_pkg::VAL_W-1:0]        r_value;
    logic                             r_out_valid;
    logic [lph_pkg::STATUS_W-1:0]     r_out_status;
    logic [lph_pkg::VAL_W-1:0]        r_out_value;

    logic                             in_accept;
    logic                             out_free;
    logic                             out_load;
    logic [lph_pkg::STATUS_W-1:0]     out_status;
    logic [lph_pkg::VAL_W-1:0]        out_value;
    logic                             h_done;
    logic [SLOT_W-1:0]                h_home;
    logic [SLOT_W-1:0]                next_slot;
    logic                             slot_free;
    logic                             key_match;
    logic                             probe_end;
    logic                             wr_en;
    logic [SLOT_W-1:0]                wr_addr;
    lph_pkg::t_entry                  wr_data;
    logic [SLOT_W-1:0]                rd_addr;
    lph_pkg::t_entry                  rd_data;

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign out_free      = !r_out_valid || m_axis_tready;

    lph_hash #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .SLOT_W      (SLOT_W)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_accept),
        .i_key   (s_axis_tdata[31:0]),
        .o_done  (h_done),
        .o_home  (h_home)
    );

    lph_store #(
        .DEPTH  (TABLE_SLOTS),
        .ADDR_W (SLOT_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign next_slot = (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
    assign slot_free = !rd_data.occ;
    assign key_match = rd_data.key == r_key;
    assign probe_end = slot_free || (r_action == lph_pkg::ACT_FIND && key_match) ||
                       (r_probes == LAST_SLOT);

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_slot     = r_slot;
        n_probes   = r_probes;
        rd_addr    = r_slot;
        wr_en      = 1'b0;
        wr_addr    = r_slot;
        wr_data    = '{occ: 1'b1, key: r_key, value: r_value};
        out_load   = 1'b0;
        out_status = lph_pkg::ST_NOT_FOUND;
        out_value  = '0;
        case (r_state)
            S_CLEAR: begin
                wr_en      = 1'b1;
                wr_addr    = r_clr_addr;
                wr_data    = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_SLOT) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                if (h_done) begin
                    rd_addr  = h_home;
                    n_slot   = h_home;
                    n_probes = '0;
                    n_state  = S_PROBE;
                end
            end
            S_PROBE: begin
                if (probe_end) begin
                    // hold on the same slot while the result register is still taken
                    if (out_free) begin
                        out_load = 1'b1;
                        n_state  = S_IDLE;
                        if (r_action == lph_pkg::ACT_INSERT) begin
                            if (slot_free) begin
                                wr_en      = 1'b1;
                                out_status = lph_pkg::ST_OK;
                            end else begin
                                out_status = lph_pkg::ST_FULL;
                            end
                        end else if (!slot_free && key_match) begin
                            out_status = lph_pkg::ST_OK;
                            out_value  = rd_data.value;
                        end
                    end
                end else begin
                    rd_addr  = next_slot;
                    n_slot   = next_slot;
                    n_probes = r_probes + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot   <= n_slot;
        r_probes <= n_probes;
        if (in_accept) begin
            r_action <= s_axis_tuser[0];
            r_key    <= s_axis_tdata[31:0];
            r_value  <= s_axis_tdata[63:32];
        end
        if (out_load) begin
            r_out_status <= out_status;
            r_out_value  <= out_value;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_value;
    assign m_axis_tuser  = r_out_status;

    // an insert only ever writes a slot that was read as empty
    a_write_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && r_state == S_PROBE) |-> !rd_data.occ)
        else $error("insert wrote an occupied slot");

    // a result is loaded only into a free output register
    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || m_axis_tready))
        else $error("result overwrote a pending item");

    // only a successful find carries a nonzero value
    a_value_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != lph_pkg::ST_OK) |-> (r_out_value == '0))
        else $error("nonzero value with failing status");

    // no item is taken until the clearing pass has finished
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_state == S_CLEAR && r_clr_addr != LAST_SLOT) |-> !s_axis_tready)
        else $error("item accepted during clearing pass");

endmodule

// File: verif/linear_probe_hash_table_tb.sv
// linear_probe_hash_table_tb: stream-level test of the linear probing hash table
// mirrors the slot store in a scoreboard class and checks every reply in order
// depends on lph_pkg and linear_probe_hash_table
`timescale 1ns / 100ps

class probe_table_mirror #(int SLOTS = 1024);
    typedef struct packed {
        logic [lph_pkg::STATUS_W-1:0] status;
        logic [lph_pkg::VAL_W-1:0]    value;
    } t_reply;

    bit                       occupied [SLOTS];
    logic [lph_pkg::KEY_W-1:0] slot_key [SLOTS];
    logic [lph_pkg::VAL_W-1:0] slot_val [SLOTS];
    int                       filled;
    int                       mismatches;
    t_reply                   awaited_replies[$];

    function t_reply probe_walk(logic act, logic [31:0] key, logic [31:0] val);
        t_reply     r;
        logic [33:0] start;
        int         s;
        r.status = (act == lph_pkg::ACT_INSERT) ? lph_pkg::ST_FULL : lph_pkg::ST_NOT_FOUND;
        r.value  = '0;
        start    = {1'b0, key, 1'b0} + 34'(SLOTS - 1);
        s        = int'(start % SLOTS);
        for (int n = 0; n < SLOTS; n++) begin
            if (!occupied[s]) begin
                if (act == lph_pkg::ACT_INSERT) begin
                    occupied[s] = 1'b1;
                    slot_key[s] = key;
                    slot_val[s] = val;
                    filled++;
                    r.status = lph_pkg::ST_OK;
                end
                break;
            end
            if (act == lph_pkg::ACT_FIND && slot_key[s] == key) begin
                r.status = lph_pkg::ST_OK;
                r.value  = slot_val[s];
                break;
            end
            s = (s + 1) % SLOTS;
        end
        return r;
    endfunction

    function void note_request(logic act, logic [31:0] key, logic [31:0] val);
        awaited_replies.push_back(probe_walk(act, key, val));
    endfunction

    function void check_reply(logic [1:0] status, logic [31:0] value);
        t_reply exp;
        if (awaited_replies.size() == 0) begin
            $display("%0t: unexpected reply, status %0d value %h", $time, status, value);
            mismatches++;
            return;
        end
        exp = awaited_replies.pop_front();
        if (status !== exp.status) begin
            $display("%0t: status expected %0d got %0d", $time, exp.status, status);
            mismatches++;
        end
        if (value !== exp.value) begin
            $display("%0t: read_value expected %h got %h", $time, exp.value, value);
            mismatches++;
        end
    endfunction
endclass

module linear_probe_hash_table_tb;

    localparam int TABLE_SLOTS = 1024;
    localparam int CYCLE_LIMIT = 12_000_000;
    localparam int SETTLE      = 64;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // key [31:0], value [63:32]
    logic [0:0]  s_axis_tuser;   // action [0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // read_value [31:0]
    logic [1:0]  m_axis_tuser;   // status [1:0]

    int send_idle_pct;
    int recv_idle_pct;
    logic [31:0] stored_keys[$];

    probe_table_mirror #(TABLE_SLOTS) board;

    linear_probe_hash_table #(.TABLE_SLOTS(TABLE_SLOTS)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            board.check_reply(m_axis_tuser, m_axis_tdata);
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("linear_probe_hash_table_tb NOT OK");
        $finish;
    end

    // entered and left at a falling edge
    task automatic push_item(input logic act, input logic [31:0] key, input logic [31:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {val, key};
        s_axis_tuser  <= act;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_request(act, key, val);
        if (act == lph_pkg::ACT_INSERT) stored_keys.push_back(key);
        @(negedge i_clk);
    endtask

    task automatic random_item(input int insert_pct);
        logic        act;
        logic [31:0] key;
        act = ($urandom_range(99) < insert_pct) ? lph_pkg::ACT_INSERT : lph_pkg::ACT_FIND;
        if (stored_keys.size() != 0 &&
            $urandom_range(99) < ((act == lph_pkg::ACT_FIND) ? 70 : 15)) begin
            key = stored_keys[$urandom_range(stored_keys.size() - 1)];
        end else if ($urandom_range(1) == 0) begin
            key = $urandom;
        end else begin
            key = $urandom_range(2047);
        end
        push_item(act, key, $urandom);
    endtask

    task automatic drain_replies();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (board.awaited_replies.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = lph_pkg::ACT_INSERT;
        send_idle_pct = 37;
        recv_idle_pct = 63;
        board = new();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // wrap at the top slot, duplicates, colliding keys, extreme values
        push_item(lph_pkg::ACT_FIND,   32'h0000_0000, 32'h0000_0000);
        push_item(lph_pkg::ACT_INSERT, 32'h0000_0000, 32'h7fff_ffff);
        push_item(lph_pkg::ACT_INSERT, 32'h0000_0000, 32'h8000_0000);
        push_item(lph_pkg::ACT_FIND,   32'h0000_0000, 32'h0000_0000);
        push_item(lph_pkg::ACT_INSERT, 32'h0000_0200, 32'hffff_ffff);
        push_item(lph_pkg::ACT_FIND,   32'h0000_0200, 32'h0000_0000);
        push_item(lph_pkg::ACT_INSERT, 32'hffff_ffff, 32'h0000_0000);
        push_item(lph_pkg::ACT_FIND,   32'hffff_ffff, 32'haaaa_aaaa);
        push_item(lph_pkg::ACT_INSERT, 32'h8000_0000, 32'h1234_5678);
        push_item(lph_pkg::ACT_FIND,   32'h8000_0000, 32'h5555_5555);
        push_item(lph_pkg::ACT_FIND,   32'h0000_0001, 32'h0000_0000);
        push_item(lph_pkg::ACT_INSERT, 32'h0000_0001, 32'h5555_5555);
        push_item(lph_pkg::ACT_FIND,   32'h0000_0001, 32'hffff_ffff);
        push_item(lph_pkg::ACT_INSERT, 32'h0000_01ff, 32'h0000_0000);
        push_item(lph_pkg::ACT_FIND,   32'h2000_01ff, 32'h0000_0000);
        drain_replies();

        repeat (600) random_item(40);
        drain_replies();

        send_idle_pct = 63;
        recv_idle_pct = 37;
        repeat (600) random_item(50);
        drain_replies();

        // fill the table, then work against a full one
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (board.filled < TABLE_SLOTS) random_item(80);
        repeat (50) random_item(50);
        drain_replies();

        repeat (SETTLE) @(negedge i_clk);
        if (board.mismatches == 0 && board.awaited_replies.size() == 0) begin
            $display("linear_probe_hash_table_tb OK");
        end else begin
            $display("linear_probe_hash_table_tb NOT OK");
        end
        $finish;
    end
endmodule
